### rtl/core/pdh_pkg.sv
// pdh_pkg: shared types, codes and the opcode decoder for the decode/hazard/forward block
// no dependencies; used by the interfaces and every module under rtl/core
package pdh_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned RLEN = 5;
  localparam int unsigned CLEN = 3;
  localparam int unsigned SLEN = 2;

  // write classes
  localparam logic [CLEN-1:0] CLS_NONE  = 3'd0;
  localparam logic [CLEN-1:0] CLS_RTYPE = 3'd1;
  localparam logic [CLEN-1:0] CLS_IMM   = 3'd2;
  localparam logic [CLEN-1:0] CLS_LOAD  = 3'd3;
  localparam logic [CLEN-1:0] CLS_STORE = 3'd4;

  // next pc select
  localparam logic [SLEN-1:0] PC_SEQ    = 2'd0;
  localparam logic [SLEN-1:0] PC_TAKEN  = 2'd1;
  localparam logic [SLEN-1:0] PC_JUMP   = 2'd2;

  // opcodes and function codes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] FN_JR      = 6'h08;

  localparam logic [RLEN-1:0] REG_ZERO = 5'd0;

  typedef struct packed {
    logic [XLEN-1:0] instr_word;
    logic [XLEN-1:0] seq_pc;
    logic [XLEN-1:0] rf_rs_data;
    logic [XLEN-1:0] rf_rt_data;
    logic [CLEN-1:0] exmem_class;
    logic [RLEN-1:0] exmem_dest;
    logic [XLEN-1:0] exmem_result;
    logic [CLEN-1:0] memwb_class;
    logic [RLEN-1:0] memwb_dest;
    logic [XLEN-1:0] memwb_alu_result;
    logic [XLEN-1:0] memwb_load_data;
  } in_item_t;

  typedef struct packed {
    logic            stall_out;
    logic            flush_out;
    logic [SLEN-1:0] pc_select;
    logic [XLEN-1:0] pc_target;
    logic [XLEN-1:0] operand_a;
    logic [XLEN-1:0] operand_b;
    logic [XLEN-1:0] latched_instr;
    logic [CLEN-1:0] decoded_class;
    logic [XLEN-1:0] imm_extended;
    logic            target_overflow;
  } out_item_t;

  // fields of the instruction in decode
  typedef struct packed {
    logic [5:0]      op;
    logic [5:0]      fn;
    logic [RLEN-1:0] rs;
    logic [RLEN-1:0] rt;
    logic [RLEN-1:0] rd;
    logic [CLEN-1:0] cls;
    logic            br;
    logic [XLEN-1:0] sext;
  } dec_t;

  function automatic logic [CLEN-1:0] classify(input logic [5:0] op);
    logic [CLEN-1:0] c;
    unique case (op) inside
      OP_SPECIAL:                                c = CLS_RTYPE;
      OP_ADDI, OP_LUI, OP_ANDI, OP_ORI, OP_XORI, OP_SLTI: c = CLS_IMM;
      OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU:       c = CLS_LOAD;
      OP_SW, OP_SH, OP_SB:                       c = CLS_STORE;
      default:                                   c = CLS_NONE;
    endcase
    return c;
  endfunction

  function automatic dec_t decode(input logic [XLEN-1:0] ins);
    dec_t d;
    d.op   = ins[31:26];
    d.fn   = ins[5:0];
    d.rs   = ins[25:21];
    d.rt   = ins[20:16];
    d.rd   = ins[15:11];
    d.cls  = classify(ins[31:26]);
    d.br   = (ins[31:26] == OP_BEQ) || (ins[31:26] == OP_BNE);
    d.sext = {{(XLEN-16){ins[15]}}, ins[15:0]};
    return d;
  endfunction

endpackage

### rtl/core/pdh_in_if.sv
// pdh_in_if: instruction channel into the decode/hazard/forward block
// depends on pdh_pkg
interface pdh_in_if;
  import pdh_pkg::*;

  logic            valid;
  logic            ready;
  logic [XLEN-1:0] instr_word;
  logic [XLEN-1:0] seq_pc;
  logic [XLEN-1:0] rf_rs_data;
  logic [XLEN-1:0] rf_rt_data;
  logic [CLEN-1:0] exmem_class;
  logic [RLEN-1:0] exmem_dest;
  logic [XLEN-1:0] exmem_result;
  logic [CLEN-1:0] memwb_class;
  logic [RLEN-1:0] memwb_dest;
  logic [XLEN-1:0] memwb_alu_result;
  logic [XLEN-1:0] memwb_load_data;

  modport source (
    output valid, instr_word, seq_pc, rf_rs_data, rf_rt_data, exmem_class, exmem_dest,
           exmem_result, memwb_class, memwb_dest, memwb_alu_result, memwb_load_data,
    input  ready
  );

  modport sink (
    input  valid, instr_word, seq_pc, rf_rs_data, rf_rt_data, exmem_class, exmem_dest,
           exmem_result, memwb_class, memwb_dest, memwb_alu_result, memwb_load_data,
    output ready
  );
endinterface

### rtl/core/pdh_out_if.sv
// pdh_out_if: result channel out of the decode/hazard/forward block
// depends on pdh_pkg
interface pdh_out_if;
  import pdh_pkg::*;

  logic            valid;
  logic            ready;
  logic            stall_out;
  logic            flush_out;
  logic [SLEN-1:0] pc_select;
  logic [XLEN-1:0] pc_target;
  logic [XLEN-1:0] operand_a;
  logic [XLEN-1:0] operand_b;
  logic [XLEN-1:0] latched_instr;
  logic [CLEN-1:0] decoded_class;
  logic [XLEN-1:0] imm_extended;
  logic            target_overflow;

  modport source (
    output valid, stall_out, flush_out, pc_select, pc_target, operand_a, operand_b,
           latched_instr, decoded_class, imm_extended, target_overflow,
    input  ready
  );

  modport sink (
    input  valid, stall_out, flush_out, pc_select, pc_target, operand_a, operand_b,
           latched_instr, decoded_class, imm_extended, target_overflow,
    output ready
  );
endinterface

### rtl/core/pdh_hazard.sv
// pdh_hazard: load-use and branch hazard detection against the previous decode
// depends on pdh_pkg; holds the class and destination of the last sent instruction
module pdh_hazard (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  pdh_pkg::dec_t             dec,
  input  logic [pdh_pkg::CLEN-1:0]  exmem_class,
  input  logic [pdh_pkg::RLEN-1:0]  exmem_dest,
  output logic                      stall
);
  import pdh_pkg::*;

  logic [CLEN-1:0] prior_class;
  logic [RLEN-1:0] prior_dest;
  logic            load_use;
  logic            br_alu;
  logic            br_load;

  always_comb begin
    load_use = (prior_class == CLS_LOAD) && (prior_dest != REG_ZERO) &&
               ((prior_dest == dec.rs) || ((prior_dest == dec.rt) && (dec.cls != CLS_IMM)));
    br_alu   = dec.br && ((prior_class == CLS_RTYPE) || (prior_class == CLS_IMM)) &&
               (prior_dest != REG_ZERO) && ((prior_dest == dec.rs) || (prior_dest == dec.rt));
    br_load  = dec.br && (exmem_class == CLS_LOAD) && (exmem_dest != REG_ZERO) &&
               ((exmem_dest == dec.rs) || (exmem_dest == dec.rt));
    stall    = load_use || br_alu || br_load;
  end

  // a bubble leaves nothing behind to hazard against
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_class <= CLS_NONE;
      prior_dest  <= REG_ZERO;
    end else if (advance) begin
      if (stall) begin
        prior_class <= CLS_NONE;
        prior_dest  <= REG_ZERO;
      end else begin
        prior_class <= dec.cls;
        prior_dest  <= (dec.cls == CLS_RTYPE) ? dec.rd : dec.rt;
      end
    end
  end

  a_bubble_clears: assert property (@(posedge clk) disable iff (rst)
    advance && stall |=> prior_class == CLS_NONE && prior_dest == REG_ZERO)
    else $error("prior decode not cleared after bubble");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(prior_class) && $stable(prior_dest))
    else $error("prior decode changed without a transaction");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> prior_class == CLS_NONE && prior_dest == REG_ZERO)
    else $error("prior decode not cleared by reset");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    prior_class == CLS_NONE && !dec.br |-> !stall)
    else $error("stall raised with no hazard source");

endmodule

### rtl/core/pdh_resolve.sv
// pdh_resolve: operand forwarding, branch and jump resolution, result assembly
// depends on pdh_pkg; purely combinational between the input and result registers
module pdh_resolve (
  input  pdh_pkg::in_item_t  item,
  input  pdh_pkg::dec_t      dec,
  input  logic               stall,
  output pdh_pkg::out_item_t res
);
  import pdh_pkg::*;

  logic [XLEN-1:0] fwd_a;
  logic [XLEN-1:0] fwd_b;
  logic [XLEN-1:0] offset;
  logic [XLEN-1:0] br_target;
  logic            overflow;
  logic            taken;

  function automatic logic [XLEN-1:0] forward(
    input logic [RLEN-1:0] r,
    input logic            br,
    input logic [XLEN-1:0] rf,
    input in_item_t        it
  );
    logic [XLEN-1:0] v;
    v = rf;
    if (br && ((it.exmem_class == CLS_RTYPE) || (it.exmem_class == CLS_IMM)) &&
        (it.exmem_dest != REG_ZERO) && (it.exmem_dest == r)) begin
      v = it.exmem_result;
    end else if ((it.memwb_dest != REG_ZERO) && (it.memwb_dest == r)) begin
      if (it.memwb_class == CLS_LOAD) begin
        v = it.memwb_load_data;
      end else if ((it.memwb_class == CLS_RTYPE) || (it.memwb_class == CLS_IMM)) begin
        v = it.memwb_alu_result;
      end
    end
    return v;
  endfunction

  always_comb begin
    fwd_a     = forward(dec.rs, dec.br, item.rf_rs_data, item);
    fwd_b     = forward(dec.rt, dec.br, item.rf_rt_data, item);
    offset    = {dec.sext[XLEN-3:0], 2'b00};
    br_target = item.seq_pc + offset;
    // overflow is flagged from the current immediate even when stalled
    overflow  = dec.br && !(item.seq_pc[XLEN-1] ^ offset[XLEN-1]) &&
                (item.seq_pc[XLEN-1] ^ br_target[XLEN-1]);
    taken     = ((dec.op == OP_BEQ) && (fwd_a == fwd_b)) ||
                ((dec.op == OP_BNE) && (fwd_a != fwd_b));

    res                 = '0;
    res.stall_out       = stall;
    res.target_overflow = overflow;
    if (!stall) begin
      res.operand_a     = fwd_a;
      res.operand_b     = fwd_b;
      res.latched_instr = item.instr_word;
      res.decoded_class = dec.cls;
      res.imm_extended  = dec.sext;
      if (taken) begin
        res.pc_select = PC_TAKEN;
        res.pc_target = br_target;
        res.flush_out = 1'b1;
      end
      if ((dec.op == OP_SPECIAL) && (dec.fn == FN_JR)) begin
        res.pc_select = PC_JUMP;
        res.pc_target = fwd_a;
        res.flush_out = 1'b1;
      end else if ((dec.op == OP_J) || (dec.op == OP_JAL)) begin
        res.pc_select = PC_JUMP;
        res.pc_target = {item.seq_pc[XLEN-1:XLEN-4], item.instr_word[25:0], 2'b00};
        res.flush_out = 1'b1;
      end
    end
  end

endmodule

### rtl/core/pipeline_decode_hazard_forward_top.sv
// pipeline_decode_hazard_forward_top: decode stage hazard detection and operand forwarding
// depends on pdh_pkg, pdh_in_if, pdh_out_if, pdh_hazard and pdh_resolve
//
// usage:
//   din carries one instruction in decode per transaction together with its pc+4,
//   register file reads and the class, destination and results of the EX/MEM and
//   MEM/WB latches. dout returns one result per instruction: stall, flush, next-pc
//   select and target, forwarded operands, the instruction sent on (zero for a
//   bubble), its write class, sign-extended immediate and branch target overflow.
//   an accepted instruction sits in an input register, the decode, hazard and
//   forwarding logic fills the result register when the input register advances,
//   and dout.valid rises once the result register is loaded. one instruction per
//   cycle is sustained while dout does not stall; the only loop is the update of
//   the previous-decode register.
//   when dout stalls, the result register holds, the input register keeps its
//   instruction and din.ready drops once both are full; nothing is lost.
//   reset clears both registers' valid flags and the previous-decode state
//   (class none, destination zero).
module pipeline_decode_hazard_forward_top (
  input  logic clk,
  input  logic rst,
  pdh_in_if.sink    din,
  pdh_out_if.source dout
);
  import pdh_pkg::*;

  in_item_t  stage;
  logic      stage_valid;
  out_item_t result;
  logic      result_valid;
  dec_t      dec;
  logic      stall;
  logic      advance;
  out_item_t res_next;

  assign advance  = stage_valid && (!result_valid || dout.ready);
  assign din.ready = !stage_valid || advance;
  assign dec      = decode(stage.instr_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (din.ready) begin
      stage_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      stage.instr_word       <= din.instr_word;
      stage.seq_pc           <= din.seq_pc;
      stage.rf_rs_data       <= din.rf_rs_data;
      stage.rf_rt_data       <= din.rf_rt_data;
      stage.exmem_class      <= din.exmem_class;
      stage.exmem_dest       <= din.exmem_dest;
      stage.exmem_result     <= din.exmem_result;
      stage.memwb_class      <= din.memwb_class;
      stage.memwb_dest       <= din.memwb_dest;
      stage.memwb_alu_result <= din.memwb_alu_result;
      stage.memwb_load_data  <= din.memwb_load_data;
    end
  end

  pdh_hazard u_hazard (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .dec         (dec),
    .exmem_class (stage.exmem_class),
    .exmem_dest  (stage.exmem_dest),
    .stall       (stall)
  );

  pdh_resolve u_resolve (
    .item  (stage),
    .dec   (dec),
    .stall (stall),
    .res   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (dout.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

  assign dout.valid           = result_valid;
  assign dout.stall_out       = result.stall_out;
  assign dout.flush_out       = result.flush_out;
  assign dout.pc_select       = result.pc_select;
  assign dout.pc_target       = result.pc_target;
  assign dout.operand_a       = result.operand_a;
  assign dout.operand_b       = result.operand_b;
  assign dout.latched_instr   = result.latched_instr;
  assign dout.decoded_class   = result.decoded_class;
  assign dout.imm_extended    = result.imm_extended;
  assign dout.target_overflow = result.target_overflow;

  a_bubble_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.stall_out |->
      result.pc_select == PC_SEQ && !result.flush_out && result.decoded_class == CLS_NONE)
    else $error("bubble carries a redirect or a class");

  a_flush_redirects: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.flush_out |-> result.pc_select != PC_SEQ)
    else $error("flush without a redirect");

  a_stage_kept: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage))
    else $error("held instruction lost from input register");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    result_valid && !dout.ready |=> result_valid && $stable(result))
    else $error("stalled result dropped or changed");

endmodule
